// ===== rtl/core/pnsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnsp_pkg
// Shared opcodes, status codes and controller command/status types.
// ----------------------------------------------------------------------------
package pnsp_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  // datapath commands
  typedef struct packed {
    logic clear;      // vertex_count <= 0
    logic append;     // write vertex, count++
    logic latch_q;    // capture query point
    logic scan_addr;  // drive scan address k
    logic scan_first; // first scan sample
    logic seg_setup;  // compute prev/next
    logic rd_a;       // read projection vertex A (sel seg)
    logic rd_b;       // read projection vertex B
    logic cap_a;      // capture A data
    logic cap_b;      // capture B data
    logic prj_start;  // start projection of selected segment
    logic prj_sel;    // 0 outgoing, 1 incoming
    logic prj_save;   // store projection result
    logic pick;       // final select
  } pnsp_cmd_t;

  typedef struct packed {
    logic scan_last;  // last scan address issued
    logic prj_done;
    logic few;
    logic full;
  } pnsp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/pnsp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnsp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pnsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read of the old contents every cycle
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/pnsp_proj.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnsp_proj
// Projection of a point onto one segment: exact dot products, restoring
// divider one quotient bit per cycle, then projected point and distance.
// ----------------------------------------------------------------------------
module pnsp_proj #(
  parameter int LFB = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] px,
  input  wire logic signed [31:0] py,
  input  wire logic signed [31:0] ax,
  input  wire logic signed [31:0] ay,
  input  wire logic signed [31:0] bx,
  input  wire logic signed [31:0] by,
  output      logic               done,
  output      logic [LFB:0]       lam,
  output      logic [63:0]        dsq
);
  localparam logic [2:0] P_IDLE = 3'd0, P_MUL = 3'd1, P_SUM = 3'd2, P_DIV = 3'd3,
                         P_OFS = 3'd4, P_DPT = 3'd5, P_SQ = 3'd6, P_FIN = 3'd7;
  localparam int CW = $clog2(LFB + 1);

  logic [2:0] state;
  logic [CW-1:0] cnt;
  logic signed [32:0] ux, uy, wx, wy;
  logic [32:0] mux, muy;
  logic [65:0] pxu, pyu, uxx, uyy;
  logic sxu, syu;
  logic [67:0] pos, neg, uu, rem;
  logic [LFB:0] q;
  logic [65:0] ox, oy;
  logic signed [34:0] qx, qy, dx, dy;
  logic [34:0] adx, ady;
  logic [69:0] sqx, sqy;
  logic [70:0] ssum;
  logic [67:0] rsh;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : v;
  endfunction
  function automatic logic [34:0] mag35(input logic signed [34:0] v);
    mag35 = v[34] ? 35'(-v) : v;
  endfunction

  assign rsh = {rem[66:0], 1'b0};

  // offsets from the projected point and the final distance sum
  assign dx   = 35'(px) - qx;
  assign dy   = 35'(py) - qy;
  assign adx  = mag35(dx);
  assign ady  = mag35(dy);
  assign ssum = 71'(sqx) + 71'(sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        P_IDLE: if (start) begin
          ux <= 33'(bx) - 33'(ax);
          uy <= 33'(by) - 33'(ay);
          wx <= 33'(px) - 33'(ax);
          wy <= 33'(py) - 33'(ay);
          state <= P_MUL;
        end
        // one product per term, sign tracked apart
        P_MUL: begin
          pxu <= mag33(wx) * mag33(ux);
          pyu <= mag33(wy) * mag33(uy);
          uxx <= mag33(ux) * mag33(ux);
          uyy <= mag33(uy) * mag33(uy);
          sxu <= wx[32] ^ ux[32];
          syu <= wy[32] ^ uy[32];
          mux <= mag33(ux);
          muy <= mag33(uy);
          state <= P_SUM;
        end
        P_SUM: begin
          pos <= (sxu ? 68'd0 : 68'(pxu)) + (syu ? 68'd0 : 68'(pyu));
          neg <= (sxu ? 68'(pxu) : 68'd0) + (syu ? 68'(pyu) : 68'd0);
          uu  <= 68'(uxx) + 68'(uyy);
          state <= P_FIN;
          cnt <= '0;
          q <= '0;
        end
        // classify, then divide; on the pass after the distance squares, report
        P_FIN: begin
          if (cnt == '0) begin
            if (uu == 68'd0 || neg >= pos) begin
              q <= '0;
              qx <= 35'(ax); qy <= 35'(ay);
              state <= P_DPT;
            end else if (pos >= neg + uu) begin
              q <= (LFB+1)'(1) << LFB;
              qx <= 35'(bx); qy <= 35'(by);
              state <= P_DPT;
            end else begin
              rem <= pos - neg;
              state <= P_DIV;
            end
          end else begin
            // saturate the distance sum and report
            dsq <= (ssum[70:64] != 7'd0) ? {64{1'b1}} : ssum[63:0];
            lam <= q;
            done <= 1'b1;
            state <= P_IDLE;
          end
        end
        P_DIV: begin
          if (rsh >= uu) begin
            rem <= rsh - uu;
            q <= {q[LFB-1:0], 1'b1};
          end else begin
            rem <= rsh;
            q <= {q[LFB-1:0], 1'b0};
          end
          if (cnt == CW'(LFB - 1)) state <= P_OFS;
          cnt <= cnt + 1'b1;
        end
        P_OFS: begin
          ox <= mux * 33'(q);
          oy <= muy * 33'(q);
          state <= P_SQ;
        end
        P_SQ: begin
          qx <= 35'(ax) + (ux[32] ? -35'(((ox + (66'd1 << (LFB-1))) >> LFB))
                                  :  35'(((ox + (66'd1 << (LFB-1))) >> LFB)));
          qy <= 35'(ay) + (uy[32] ? -35'(((oy + (66'd1 << (LFB-1))) >> LFB))
                                  :  35'(((oy + (66'd1 << (LFB-1))) >> LFB)));
          state <= P_DPT;
        end
        P_DPT: begin
          sqx <= adx * adx;
          sqy <= ady * ady;
          cnt <= CW'(1);
          state <= P_FIN;
        end
        default: state <= P_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/pnsp_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnsp_dp
// Datapath: vertex stores, count, nearest-vertex scan and segment selection.
// ----------------------------------------------------------------------------
module pnsp_dp
  import pnsp_pkg::*;
#(
  parameter int MAX_VERTICES     = 1024,
  parameter int LAMBDA_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pnsp_cmd_t          cmd,
  output      pnsp_sts_t          sts,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  output      logic [9:0]         seg_out,
  output      logic [16:0]        lam_out,
  output      logic [63:0]        dist_out
);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int LW = LAMBDA_FRAC_BITS + 1;

  logic [CW-1:0] count;
  logic [AW-1:0] k, kd, best_n, prev, next, addr;
  logic signed [31:0] qx, qy, rx, ry, ax, ay, bx, by;
  logic [63:0] best, d_o, d_i;
  logic [LW-1:0] l_o, l_i;
  logic prj_done;
  logic [LW-1:0] plam;
  logic [63:0] pdist;
  logic [32:0] ddx, ddy;
  logic [64:0] dsum;
  logic [63:0] sqa, sqb;
  logic sq_v, sq_v2;
  logic [AW-1:0] sq_k;

  assign sts.few       = (count < CW'(3));
  assign sts.full      = (count >= CW'(MAX_VERTICES));
  assign sts.scan_last = (CW'(k) == count - 1'b1);
  assign sts.prj_done  = prj_done;

  // one address into both stores
  always_comb begin
    addr = k;
    if (cmd.append)    addr = count[AW-1:0];
    else if (cmd.rd_a) addr = cmd.prj_sel ? prev : best_n;
    else if (cmd.rd_b) addr = cmd.prj_sel ? best_n : next;
  end

  pnsp_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram_x (
    .clk(clk), .we(cmd.append), .addr(addr), .wdata(in_x), .rdata(rx));
  pnsp_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram_y (
    .clk(clk), .we(cmd.append), .addr(addr), .wdata(in_y), .rdata(ry));

  // scan pipeline: address, read, square, compare
  always_comb begin
    ddx = (33'(qx) - 33'(rx));
    ddy = (33'(qy) - 33'(ry));
    if (ddx[32]) ddx = -ddx;
    if (ddy[32]) ddy = -ddy;
    dsum = 65'(sqa) + 65'(sqb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sq_v  <= 1'b0;
      sq_v2 <= 1'b0;
    end else begin
      if (cmd.clear) count <= '0;
      else if (cmd.append) count <= count + 1'b1;
      sq_v  <= cmd.scan_addr;
      sq_v2 <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_q) begin
      qx <= in_x; qy <= in_y; k <= '0;
    end else if (cmd.scan_addr) begin
      k <= k + 1'b1;
    end
    kd    <= k;
    sq_k  <= kd;
    sqa   <= ddx[31:0] * ddx[31:0];
    sqb   <= ddy[31:0] * ddy[31:0];
    if (sq_v2) begin
      if (cmd.scan_first || 64'((dsum[64] ? {64{1'b1}} : dsum[63:0])) < best) begin
        best   <= dsum[64] ? {64{1'b1}} : dsum[63:0];
        best_n <= sq_k;
      end
    end
    if (cmd.seg_setup) begin
      next <= (CW'(best_n) + 1'b1 == count) ? '0 : best_n + 1'b1;
      prev <= (best_n == '0) ? AW'(count - 1'b1) : best_n - 1'b1;
    end
    if (cmd.cap_a) begin ax <= rx; ay <= ry; end
    if (cmd.cap_b) begin bx <= rx; by <= ry; end
    if (cmd.prj_save) begin
      if (cmd.prj_sel) begin l_i <= plam; d_i <= pdist; end
      else begin l_o <= plam; d_o <= pdist; end
    end
    if (cmd.pick) begin
      if (d_i < d_o) begin
        seg_out <= 10'(prev); lam_out <= 17'(l_i); dist_out <= d_i;
      end else begin
        seg_out <= 10'(best_n); lam_out <= 17'(l_o); dist_out <= d_o;
      end
    end
  end

  pnsp_proj #(.LFB(LAMBDA_FRAC_BITS)) u_proj (
    .clk(clk), .rst(rst), .start(cmd.prj_start),
    .px(qx), .py(qy), .ax(ax), .ay(ay), .bx(bx), .by(by),
    .done(prj_done), .lam(plam), .dsq(pdist));
endmodule
`default_nettype wire

// ===== rtl/core/pnsp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnsp_ctrl
// Controller: handshakes, scan sequencing and projection sequencing.
// ----------------------------------------------------------------------------
module pnsp_ctrl
  import pnsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] opcode,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [1:0] st,
  output      pnsp_cmd_t  cmd,
  input  wire pnsp_sts_t  sts
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DRAIN = 4'd2, S_SETUP = 4'd3,
                         S_RA = 4'd4, S_RB = 4'd5, S_CA = 4'd6, S_CB = 4'd7,
                         S_PRJ = 4'd8, S_PICK = 4'd9, S_OUT = 4'd10;
  logic [3:0] state, state_next;
  logic [1:0] drain;
  logic [1:0] fcnt;
  logic sel;
  logic acc;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.prj_sel = sel;
    case (state)
      S_IDLE: if (acc) begin
        if (opcode == OP_CLEAR) cmd.clear = 1'b1;
        else if (opcode == OP_APPEND && !sts.full) cmd.append = 1'b1;
        else if (opcode == OP_QUERY && !sts.few) begin
          cmd.latch_q = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_addr = 1'b1;
        if (sts.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: if (drain == 2'd3) state_next = S_SETUP;
      S_SETUP: begin cmd.seg_setup = 1'b1; state_next = S_RA; end
      S_RA: begin cmd.rd_a = 1'b1; state_next = S_RB; end
      S_RB: begin cmd.rd_b = 1'b1; cmd.cap_a = 1'b1; state_next = S_CB; end
      S_CB: begin cmd.cap_b = 1'b1; state_next = S_CA; end
      S_CA: begin cmd.prj_start = 1'b1; state_next = S_PRJ; end
      S_PRJ: if (sts.prj_done) begin
        cmd.prj_save = 1'b1;
        state_next = sel ? S_PICK : S_RA;
      end
      S_PICK: begin cmd.pick = 1'b1; state_next = S_OUT; end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    cmd.scan_first = (fcnt == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; drain <= '0; sel <= 1'b0;
      st <= ST_DONE;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_SCAN) drain <= '0;
      else if (state == S_DRAIN) drain <= drain + 1'b1;
      if (state == S_IDLE && acc) begin
        sel <= 1'b0;
        if (opcode == OP_CLEAR) begin st <= ST_LOAD; out_valid <= 1'b1; end
        else if (opcode == OP_APPEND) begin
          st <= sts.full ? ST_FULL : ST_LOAD; out_valid <= 1'b1;
        end else if (opcode == OP_QUERY) begin
          st <= sts.few ? ST_FEW : ST_DONE;
          if (sts.few) out_valid <= 1'b1;
        end
      end
      if (state == S_PRJ && sts.prj_done) sel <= 1'b1;
      if (state == S_OUT) out_valid <= 1'b1;
    end
  end

  // scan_first marks the first compare, behind the read and square registers
  always_ff @(posedge clk) begin
    if (rst) fcnt <= '0;
    else if (cmd.latch_q) fcnt <= '0;
    else if (fcnt != 2'd3) fcnt <= fcnt + 1'b1;
  end
endmodule
`default_nettype wire

// ===== rtl/core/polyline_nearest_segment_projection_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_nearest_segment_projection_core
// Nearest segment of a closed polygon to a query point, with projection.
// ----------------------------------------------------------------------------
//  channel | signals                                   | accepted when
//  in      | in_valid in_ready opcode point_x point_y  | in_valid & in_ready
//  out     | out_valid out_ready status segment_index   | out_valid & out_ready
//          | lambda_q16 squared_distance                |
//
// Each load is answered by one result transaction. A query's time from acceptance
// to result valid is set by the one-vertex-per-cycle scan over the N stored
// vertices through the single store port and by the bit-serial divider. One item
// is in flight at a time; a held result stalls input. Synchronous reset clears the
// vertex count and handshake state.
module polyline_nearest_segment_projection_core
  import pnsp_pkg::*;
#(
  parameter int MAX_VERTICES     = 1024,
  parameter int LAMBDA_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [1:0]         opcode,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [1:0]         status,
  output      logic [9:0]         segment_index,
  output      logic [16:0]        lambda_q16,
  output      logic [63:0]        squared_distance
);
  pnsp_cmd_t cmd;
  pnsp_sts_t sts;
  logic [1:0] st;
  logic [9:0] seg;
  logic [16:0] lam;
  logic [63:0] dsq;

  pnsp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .out_valid(out_valid), .out_ready(out_ready),
    .st(st), .cmd(cmd), .sts(sts));

  pnsp_dp #(.MAX_VERTICES(MAX_VERTICES), .LAMBDA_FRAC_BITS(LAMBDA_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_x(point_x), .in_y(point_y),
    .seg_out(seg), .lam_out(lam), .dist_out(dsq));

  // load and short-polygon results report zeros
  assign status           = st;
  assign segment_index    = (st == ST_DONE) ? seg  : '0;
  assign lambda_q16       = (st == ST_DONE) ? lam  : '0;
  assign squared_distance = (st == ST_DONE) ? dsq  : '0;
endmodule
`default_nettype wire

// ===== sim/tb_polyline_nearest_segment_projection_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_nearest_segment_projection_core
// Loads closed polygons, queries points against them and checks every
// result against a bit-accurate predictor of the scan and projection.
// ----------------------------------------------------------------------------
module tb_polyline_nearest_segment_projection_core
  import pnsp_pkg::*;
();

  localparam int NUM_VERTS = 1024;
  localparam int FRAC      = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 drain;
  } poly_cmd_t;

  typedef struct {
    logic [1:0]  st;
    logic [9:0]  seg;
    logic [16:0] lam;
    logic [63:0] dsq;
  } proj_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode = OP_CLEAR;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [9:0]         segment_index;
  logic [16:0]        lambda_q16;
  logic [63:0]        squared_distance;

  polyline_nearest_segment_projection_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .point_x(point_x), .point_y(point_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .segment_index(segment_index),
    .lambda_q16(lambda_q16), .squared_distance(squared_distance)
  );

  always #4 clk = ~clk;

  poly_cmd_t    cmd_queue[$];
  proj_result_t expected_results[$];
  int           errors = 0;
  int           n_query = 0, n_load = 0, n_full = 0, n_few = 0, n_unused = 0;
  bit           calm = 1'b0;
  bit           in_taken = 1'b0;

  // predictor copy of the polygon store
  longint       poly_x[NUM_VERTS];
  longint       poly_y[NUM_VERTS];
  int           poly_count = 0;

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] sq_dist(longint px, longint py, longint qx, longint qy);
    logic [63:0] a, b;
    logic [64:0] s;
    a = mag(px - qx) * mag(px - qx);
    b = mag(py - qy) * mag(py - qy);
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic longint lerp_offset(longint u, logic [63:0] lam);
    logic [63:0] o;
    o = (mag(u) * lam + (64'd1 << (FRAC - 1))) >> FRAC;
    return (u < 0) ? -longint'(o) : longint'(o);
  endfunction

  // projection of (px,py) onto segment ia -> ib
  task automatic project_seg(input longint px, input longint py, input int ia, input int ib,
                             output logic [63:0] lam, output logic [63:0] dsq);
    longint       ax, ay, bx, by, ux, uy, ex, ey;
    logic [127:0] uu, pos, neg, r;
    logic [63:0]  m;
    ax = poly_x[ia]; ay = poly_y[ia]; bx = poly_x[ib]; by = poly_y[ib];
    ux = bx - ax; uy = by - ay; ex = px - ax; ey = py - ay;
    uu = 128'(mag(ux) * mag(ux)) + 128'(mag(uy) * mag(uy));
    pos = '0; neg = '0;
    m = mag(ex) * mag(ux);
    if (m != 0) begin
      if ((ex < 0) != (ux < 0)) neg += 128'(m);
      else pos += 128'(m);
    end
    m = mag(ey) * mag(uy);
    if (m != 0) begin
      if ((ey < 0) != (uy < 0)) neg += 128'(m);
      else pos += 128'(m);
    end
    if (uu == 0 || neg >= pos) begin
      lam = 0;
      dsq = sq_dist(px, py, ax, ay);
    end else if (pos >= neg + uu) begin
      lam = 64'd1 << FRAC;
      dsq = sq_dist(px, py, bx, by);
    end else begin
      r = pos - neg;
      lam = 0;
      for (int i = 0; i < FRAC; i++) begin
        r = r << 1;
        lam = lam << 1;
        if (r >= uu) begin
          r -= uu;
          lam |= 64'd1;
        end
      end
      dsq = sq_dist(px, py, ax + lerp_offset(ux, lam), ay + lerp_offset(uy, lam));
    end
  endtask

  // apply one accepted command to the predictor; has is 0 when no result follows
  task automatic predict_polygon(input poly_cmd_t c, output bit has, output proj_result_t res);
    int          n, nxt, prv;
    logic [63:0] best, d, lam_o, d_o, lam_i, d_i;
    res = '{st: ST_DONE, seg: '0, lam: '0, dsq: '0};
    has = 1'b1;
    case (c.op)
      OP_CLEAR: begin
        poly_count = 0;
        res.st = ST_LOAD;
      end
      OP_APPEND: begin
        if (poly_count >= NUM_VERTS) begin
          res.st = ST_FULL;
        end else begin
          poly_x[poly_count] = c.x;
          poly_y[poly_count] = c.y;
          poly_count++;
          res.st = ST_LOAD;
        end
      end
      OP_QUERY: begin
        if (poly_count < 3) begin
          res.st = ST_FEW;
        end else begin
          n = 0;
          best = sq_dist(c.x, c.y, poly_x[0], poly_y[0]);
          for (int k = 1; k < poly_count; k++) begin
            d = sq_dist(c.x, c.y, poly_x[k], poly_y[k]);
            if (d < best) begin
              best = d;
              n = k;
            end
          end
          nxt = (n + 1 == poly_count) ? 0 : n + 1;
          prv = (n == 0) ? poly_count - 1 : n - 1;
          project_seg(c.x, c.y, n, nxt, lam_o, d_o);
          project_seg(c.x, c.y, prv, n, lam_i, d_i);
          res.seg = 10'(n); res.lam = 17'(lam_o); res.dsq = d_o;
          // incoming segment wins only when strictly nearer
          if (d_i < d_o) begin
            res.seg = 10'(prv); res.lam = 17'(lam_i); res.dsq = d_i;
          end
        end
      end
      default: has = 1'b0;
    endcase
  endtask

  // input acceptance and result checking
  always @(posedge clk) begin
    bit           has;
    proj_result_t res, exp_res;
    poly_cmd_t    c;
    in_taken <= (!rst && in_valid && in_ready);
    if (!rst && in_valid && in_ready) begin
      c = '{op: opcode, x: point_x, y: point_y, drain: 1'b0};
      predict_polygon(c, has, res);
      if (has) expected_results.insert(expected_results.size(), res);
      else n_unused++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d seg=%0d lam=%0d dsq=%0h", $time,
                 status, segment_index, lambda_q16, squared_distance);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        case (exp_res.st)
          ST_DONE: n_query++;
          ST_FEW:  n_few++;
          ST_FULL: n_full++;
          default: n_load++;
        endcase
        if (status !== exp_res.st) begin
          $display("%0t: status expected %0d got %0d", $time, exp_res.st, status);
          errors++;
        end
        if (segment_index !== exp_res.seg) begin
          $display("%0t: segment_index expected %0d got %0d", $time, exp_res.seg,
                   segment_index);
          errors++;
        end
        if (lambda_q16 !== exp_res.lam) begin
          $display("%0t: lambda_q16 expected %0d got %0d", $time, exp_res.lam, lambda_q16);
          errors++;
        end
        if (squared_distance !== exp_res.dsq) begin
          $display("%0t: squared_distance expected %0h got %0h", $time, exp_res.dsq,
                   squared_distance);
          errors++;
        end
      end
    end
  end

  // command driver with random idle bursts
  int in_gap = 0;
  always @(negedge clk) begin
    poly_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the transaction until it is accepted
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (cmd_queue.size() == 0 ||
                 (cmd_queue[0].drain && expected_results.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      c = cmd_queue.pop_front();
      opcode   <= c.op;
      point_x  <= c.x;
      point_y  <= c.y;
      in_valid <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 15);
    end
  end

  // result receiver with random stall bursts
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 15);
    end
  end

  task automatic add_cmd(input logic [1:0] op, input longint x, input longint y,
                         input bit drain = 1'b0);
    cmd_queue.insert(cmd_queue.size(), '{op: op, x: 32'(x), y: 32'(y), drain: drain});
  endtask

  function automatic longint rand_coord(int mode);
    case (mode)
      0: return longint'($signed($urandom()));
      1: return longint'($urandom_range(0, 2 * 1048576)) - 1048576;
      default: return longint'($urandom_range(0, 128)) - 64;
    endcase
  endfunction

  // stimulus
  initial begin
    int mode, nv, nq;
    // directed: empty and short polygons
    add_cmd(OP_CLEAR, 0, 0);
    add_cmd(OP_QUERY, 0, 0);
    add_cmd(OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_cmd(OP_APPEND, -32'sh8000_0000, 32'h7FFF_FFFF);
    add_cmd(OP_QUERY, 5, 5);
    add_cmd(OP_APPEND, -32'sh8000_0000, -32'sh8000_0000);
    // extreme corners, saturated distance and interior point
    add_cmd(OP_QUERY, 32'h7FFF_FFFF, -32'sh8000_0000, 1'b1);
    add_cmd(OP_QUERY, 0, 0);
    add_cmd(OP_QUERY, 12345, -6789);
    add_cmd(OP_UNUSED, -1, -1);
    // square: tie between incoming and outgoing segment at a corner
    add_cmd(OP_CLEAR, 0, 0);
    add_cmd(OP_APPEND, 0, 0);
    add_cmd(OP_APPEND, 655360, 0);
    add_cmd(OP_APPEND, 655360, 655360);
    add_cmd(OP_APPEND, 0, 655360);
    add_cmd(OP_QUERY, -327680, -327680);
    add_cmd(OP_QUERY, 300000, -1000);
    // duplicate vertex gives a zero-length segment
    add_cmd(OP_APPEND, 0, 655360);
    add_cmd(OP_QUERY, -10, 700000);
    add_cmd(OP_QUERY, 327680, 327681);
    add_cmd(OP_UNUSED, 0, 0);

    // random polygons with queries
    while (cmd_queue.size() < 480) begin
      mode = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) add_cmd(OP_UNUSED, rand_coord(0), rand_coord(0));
      add_cmd(OP_CLEAR, rand_coord(0), rand_coord(0), $urandom_range(0, 3) == 0);
      nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      for (int i = 0; i < nv; i++) add_cmd(OP_APPEND, rand_coord(mode), rand_coord(mode));
      nq = $urandom_range(1, 6);
      for (int i = 0; i < nq; i++) begin
        add_cmd(OP_QUERY, rand_coord(mode), rand_coord(mode));
        if ($urandom_range(0, 15) == 0) add_cmd(OP_UNUSED, rand_coord(0), rand_coord(0));
      end
      // one full store in the middle of the run
      if (cmd_queue.size() > 250 && cmd_queue.size() < 300) begin
        add_cmd(OP_CLEAR, 0, 0);
        for (int i = 0; i < NUM_VERTS; i++) add_cmd(OP_APPEND, rand_coord(0), rand_coord(0));
        add_cmd(OP_APPEND, rand_coord(0), rand_coord(0));
        add_cmd(OP_APPEND, rand_coord(0), rand_coord(0));
        add_cmd(OP_QUERY, rand_coord(0), rand_coord(0));
        add_cmd(OP_QUERY, rand_coord(1), rand_coord(1));
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wind down without idling for the last stretch
    while (cmd_queue.size() > 60) @(posedge clk);
    calm = 1'b1;
    while (cmd_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);

    $display("covered %0d queries, %0d loads, %0d full-store appends,", n_query, n_load,
             n_full);
    $display("%0d short-polygon queries and %0d unused opcodes", n_few, n_unused);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("timeout at %0t", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pnsp_pkg.sv
rtl/core/pnsp_ram.sv
rtl/core/pnsp_proj.sv
rtl/core/pnsp_dp.sv
rtl/core/pnsp_ctrl.sv
rtl/core/polyline_nearest_segment_projection_core.sv
sim/tb_polyline_nearest_segment_projection_core.sv
